// ===== hw/rtl/chsm_pkg.sv =====
package chsm_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DX_MIN       = 3'd2;
  localparam logic [2:0] REG_DX_MAX       = 3'd3;
  localparam logic [2:0] REG_DY_MIN       = 3'd4;
  localparam logic [2:0] REG_DY_MAX       = 3'd5;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int DIM_W = 7;
  localparam int SHIFT_W = 8;
  localparam int OUT_W = 7;

  // histogram counts saturate at all ones
  localparam int CNT_W = 16;
  // 3 bits per channel, 8x8x8 color cube
  localparam int COLOR_CODES = 512;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
  localparam logic [SHIFT_W-1:0] SHIFT_MIN_RESET = 8'hC0;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX_RESET = 8'h40;

  typedef logic [CNT_W-1:0] cnt_t;

endpackage

// ===== hw/rtl/color_histogram_shift_matcher.sv =====
// Pixel load: read, then saturating write back of two histogram entries; next pixel waits.
// Final pixel: shift search runs one bin pair per cycle on the histogram memory read ports,
//   each valid shift through SHIFT, SCAN, DRAIN and CMP, a skipped shift only through SHIFT.
// After reset and after each result a clearing pass over max(MAX_WIDTH, MAX_HEIGHT) * NUM_BINS
//   entries zeroes the histograms; pixels stall meanwhile, configuration writes are taken.
// Reset (rst, synchronous) restores register defaults and clears the raster position.
module color_histogram_shift_matcher #(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int NUM_BINS = 512
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [chsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chsm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic frame_sel,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  input  logic final_pixel,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [chsm_pkg::OUT_W-1:0] shift_x,
  output logic signed [chsm_pkg::OUT_W-1:0] shift_y
);

  localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int COL_DEPTH = MAX_WIDTH * NUM_BINS;
  localparam int ROW_DEPTH = MAX_HEIGHT * NUM_BINS;
  localparam int CAW = $clog2(COL_DEPTH);
  localparam int RAW = $clog2(ROW_DEPTH);
  localparam int CLR_N = (COL_DEPTH > ROW_DEPTH) ? COL_DEPTH : ROW_DEPTH;
  localparam int CLW = $clog2(CLR_N);
  localparam int DSW = chsm_pkg::CNT_W + 1 + BW + chsm_pkg::DIM_W;
  localparam int PW = DSW + chsm_pkg::DIM_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_BUMP  = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_CMP   = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  typedef logic [BW-1:0] bin_tab_t [chsm_pkg::COLOR_CODES];

  function automatic bin_tab_t build_bin_tab();
    bin_tab_t t;
    int r;
    r = 0;
    for (int v = 0; v < chsm_pkg::COLOR_CODES; v++) begin
      t[v] = BW'(r);
      r++;
      if (r == NUM_BINS) r = 0;
    end
    return t;
  endfunction

  localparam bin_tab_t BIN_TAB = build_bin_tab();

  // configuration registers
  logic [chsm_pkg::DIM_W-1:0] frame_width, frame_height;
  logic [chsm_pkg::SHIFT_W-1:0] dx_min, dx_max, dy_min, dy_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= chsm_pkg::DIM_RESET;
      frame_height <= chsm_pkg::DIM_RESET;
      dx_min <= chsm_pkg::SHIFT_MIN_RESET;
      dx_max <= chsm_pkg::SHIFT_MAX_RESET;
      dy_min <= chsm_pkg::SHIFT_MIN_RESET;
      dy_max <= chsm_pkg::SHIFT_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chsm_pkg::REG_FRAME_WIDTH:  frame_width <= cfg_data[chsm_pkg::DIM_W-1:0];
        chsm_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[chsm_pkg::DIM_W-1:0];
        chsm_pkg::REG_DX_MIN:       dx_min <= cfg_data;
        chsm_pkg::REG_DX_MAX:       dx_max <= cfg_data;
        chsm_pkg::REG_DY_MIN:       dy_min <= cfg_data;
        chsm_pkg::REG_DY_MAX:       dy_max <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [chsm_pkg::DIM_W-1:0] w, h;

  always_comb begin
    if (frame_width < 7'd2) w = 7'd2;
    else if (32'(frame_width) > MAX_WIDTH) w = chsm_pkg::DIM_W'(MAX_WIDTH);
    else w = frame_width;
    if (frame_height < 7'd2) h = 7'd2;
    else if (32'(frame_height) > MAX_HEIGHT) h = chsm_pkg::DIM_W'(MAX_HEIGHT);
    else h = frame_height;
  end

  // control registers
  logic [2:0] state;
  logic [CLW-1:0] clr_cnt;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic pix_sel, pix_final;
  logic [CAW-1:0] pix_caddr;
  logic [RAW-1:0] pix_raddr;
  logic axis;
  logic signed [8:0] s;
  logic [chsm_pkg::DIM_W-1:0] n_reg, i_cnt;
  logic [BW-1:0] b_cnt;
  logic rd_vld;
  logic [DSW-1:0] d_sum, best_sum;
  logic [chsm_pkg::DIM_W-1:0] best_ov;
  logic signed [8:0] best_shift;
  logic [chsm_pkg::OUT_W-1:0] sx;

  // raster position
  logic [10:0] col_e, row_e, col_inc, row_inc;
  logic [BW-1:0] in_bin;
  logic [CAW-1:0] in_caddr;
  logic [RAW-1:0] in_raddr;
  logic in_acc;

  always_comb begin
    col_e = (11'(col) >= 11'(w)) ? 11'd0 : 11'(col);
    row_e = (11'(row) >= 11'(h)) ? 11'd0 : 11'(row);
    col_inc = col_e + 11'd1;
    row_inc = row_e + 11'd1;
    in_bin = BIN_TAB[{blue[7:5], green[7:5], red[7:5]}];
    in_caddr = CAW'(CW'(col_e)) * CAW'(NUM_BINS) + CAW'(in_bin);
    in_raddr = RAW'(RW'(row_e)) * RAW'(NUM_BINS) + RAW'(in_bin);
  end

  assign in_stall = (state != ST_IDLE);
  assign in_acc = in_valid && !in_stall;

  // search datapath
  logic [chsm_pkg::DIM_W-1:0] len;
  logic signed [8:0] hi;
  logic [8:0] mag;
  logic signed [9:0] n_full, pi10, ci10;
  logic [CAW-1:0] sc_paddr, sc_caddr;
  logic [RAW-1:0] sr_paddr, sr_caddr;
  logic last_pair;

  always_comb begin
    len = axis ? h : w;
    hi = axis ? 9'(signed'(dy_max)) : 9'(signed'(dx_max));
    mag = (s < 0) ? 9'(-s) : 9'(s);
    n_full = signed'(10'(len)) - 10'sd1 - signed'(10'(mag));
    pi10 = (s > 0) ? signed'(10'(i_cnt)) + 10'(s) : signed'(10'(i_cnt));
    ci10 = (s > 0) ? signed'(10'(i_cnt)) : signed'(10'(i_cnt)) - 10'(s);
    sc_paddr = CAW'(CW'(pi10)) * CAW'(NUM_BINS) + CAW'(b_cnt);
    sc_caddr = CAW'(CW'(ci10)) * CAW'(NUM_BINS) + CAW'(b_cnt);
    sr_paddr = RAW'(RW'(pi10)) * RAW'(NUM_BINS) + RAW'(b_cnt);
    sr_caddr = RAW'(RW'(ci10)) * RAW'(NUM_BINS) + RAW'(b_cnt);
    last_pair = (i_cnt == n_reg - 7'd1) && (b_cnt == BW'(NUM_BINS - 1));
  end

  // histogram memories: previous/current x column/row
  chsm_pkg::cnt_t mem_cp [COL_DEPTH];
  chsm_pkg::cnt_t mem_cc [COL_DEPTH];
  chsm_pkg::cnt_t mem_rp [ROW_DEPTH];
  chsm_pkg::cnt_t mem_rc [ROW_DEPTH];
  chsm_pkg::cnt_t cp_q, cc_q, rp_q, rc_q;

  logic [CAW-1:0] cp_ra, cc_ra, c_wa;
  logic [RAW-1:0] rp_ra, rc_ra, r_wa;
  logic cp_we, cc_we, rp_we, rc_we;
  chsm_pkg::cnt_t c_wd, r_wd, c_old, r_old;

  always_comb begin
    if (state == ST_SCAN) begin
      cp_ra = sc_paddr;
      cc_ra = sc_caddr;
      rp_ra = sr_paddr;
      rc_ra = sr_caddr;
    end else begin
      cp_ra = in_caddr;
      cc_ra = in_caddr;
      rp_ra = in_raddr;
      rc_ra = in_raddr;
    end
    c_old = pix_sel ? cc_q : cp_q;
    r_old = pix_sel ? rc_q : rp_q;
    if (state == ST_CLEAR) begin
      c_wa = CAW'(clr_cnt);
      r_wa = RAW'(clr_cnt);
      c_wd = '0;
      r_wd = '0;
      cp_we = (32'(clr_cnt) < COL_DEPTH);
      cc_we = cp_we;
      rp_we = (32'(clr_cnt) < ROW_DEPTH);
      rc_we = rp_we;
    end else begin
      c_wa = pix_caddr;
      r_wa = pix_raddr;
      c_wd = (c_old == '1) ? c_old : c_old + 1'b1;
      r_wd = (r_old == '1) ? r_old : r_old + 1'b1;
      cp_we = (state == ST_BUMP) && !pix_sel;
      cc_we = (state == ST_BUMP) && pix_sel;
      rp_we = cp_we;
      rc_we = cc_we;
    end
  end

  always_ff @(posedge clk) begin
    if (cp_we) mem_cp[c_wa] <= c_wd;
    cp_q <= mem_cp[cp_ra];
  end

  always_ff @(posedge clk) begin
    if (cc_we) mem_cc[c_wa] <= c_wd;
    cc_q <= mem_cc[cc_ra];
  end

  always_ff @(posedge clk) begin
    if (rp_we) mem_rp[r_wa] <= r_wd;
    rp_q <= mem_rp[rp_ra];
  end

  always_ff @(posedge clk) begin
    if (rc_we) mem_rc[r_wa] <= r_wd;
    rc_q <= mem_rc[rc_ra];
  end

  // accumulate and compare
  chsm_pkg::cnt_t p_q, c_q;
  logic [DSW-1:0] abs_diff;
  logic [PW-1:0] prod_new, prod_best;

  always_comb begin
    p_q = axis ? rp_q : cp_q;
    c_q = axis ? rc_q : cc_q;
    abs_diff = (p_q > c_q) ? DSW'(p_q - c_q) : DSW'(c_q - p_q);
    prod_new = PW'(d_sum) * PW'(best_ov);
    prod_best = PW'(best_sum) * PW'(n_reg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      col <= '0;
      row <= '0;
      rd_vld <= 1'b0;
      out_valid <= 1'b0;
      axis <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLW'(CLR_N - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            pix_sel <= frame_sel;
            pix_final <= final_pixel;
            pix_caddr <= in_caddr;
            pix_raddr <= in_raddr;
            if (col_inc >= 11'(w)) begin
              col <= '0;
              row <= (row_inc >= 11'(h)) ? '0 : RW'(row_inc);
            end else begin
              col <= CW'(col_inc);
              row <= RW'(row_e);
            end
            state <= ST_BUMP;
          end
        end
        ST_BUMP: begin
          if (pix_final) begin
            axis <= 1'b0;
            s <= 9'(signed'(dx_min));
            best_sum <= DSW'({h, 1'b0});
            best_ov <= 7'd1;
            best_shift <= '0;
            state <= ST_SHIFT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SHIFT: begin
          if (s >= hi) begin
            if (!axis) begin
              sx <= best_shift[chsm_pkg::OUT_W-1:0];
              axis <= 1'b1;
              s <= 9'(signed'(dy_min));
              best_sum <= DSW'({w, 1'b0});
              best_ov <= 7'd1;
              best_shift <= '0;
            end else begin
              state <= ST_EMIT;
            end
          end else if (n_full <= 0) begin
            s <= s + 9'sd1;
          end else begin
            n_reg <= 7'(n_full);
            i_cnt <= '0;
            b_cnt <= '0;
            d_sum <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (b_cnt == BW'(NUM_BINS - 1)) begin
            b_cnt <= '0;
            i_cnt <= i_cnt + 7'd1;
          end else begin
            b_cnt <= b_cnt + 1'b1;
          end
          if (last_pair) state <= ST_DRAIN;
        end
        ST_DRAIN: state <= ST_CMP;
        ST_CMP: begin
          // later shift wins a tie
          if (prod_new <= prod_best) begin
            best_sum <= d_sum;
            best_ov <= n_reg;
            best_shift <= s;
          end
          s <= s + 9'sd1;
          state <= ST_SHIFT;
        end
        ST_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            shift_x <= sx;
            shift_y <= best_shift[chsm_pkg::OUT_W-1:0];
            axis <= 1'b0;
            col <= '0;
            row <= '0;
            clr_cnt <= '0;
            state <= ST_CLEAR;
          end
        end
        default: state <= ST_CLEAR;
      endcase
      if (rd_vld) d_sum <= d_sum + abs_diff;
    end
  end

  a_accept_bump: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_BUMP)
    else $error("accepted pixel not written back");

  a_rd_vld_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == ST_SCAN)
    else $error("accumulate outside scan");

  a_best_ov_nz: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> best_ov != '0 && n_reg != '0)
    else $error("zero overlap in compare");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT && state == ST_CLEAR)
    else $error("result not from search end");

endmodule

// ===== bench/tb_color_histogram_shift_matcher.sv =====
module tb_color_histogram_shift_matcher;

  localparam int WDOG_LIMIT = 600000;

  typedef struct {
    bit fs;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    bit fin;
  } pixel_t;

  typedef struct {
    logic signed [chsm_pkg::OUT_W-1:0] x;
    logic signed [chsm_pkg::OUT_W-1:0] y;
  } shift_pair_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [chsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [chsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic frame_sel = 0;
  logic [7:0] blue = 0, green = 0, red = 0;
  logic final_pixel = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [chsm_pkg::OUT_W-1:0] shift_x, shift_y;

  color_histogram_shift_matcher i_dut (.*);

  always #1 clk = ~clk;

  pixel_t pixel_q[$];
  shift_pair_t shift_q[$];
  int mismatches = 0;
  int sent = 0;
  int results = 0;
  bit no_idle = 0;
  int in_gap = 0;
  int out_hold = 0;
  int wdog = 0;

  // mirrored configuration and histogram state
  logic [7:0] regs_m[6];
  // 0 prev column, 1 curr column, 2 prev row, 3 curr row
  int hist[4][64][512];
  int pos_col, pos_row;

  function automatic int clamp_dim(logic [7:0] v);
    int x;
    x = v[6:0];
    if (x < 2) x = 2;
    if (x > 64) x = 64;
    return x;
  endfunction

  function automatic int search_axis(int pa, int len, int other, int lo, int hi);
    longint best_d, best_n, d;
    int s, mag, n, i, bb, pi, ci, p, c, best;
    best_d = 2 * other;
    best_n = 1;
    best = 0;
    for (s = lo; s < hi; s++) begin
      mag = s < 0 ? -s : s;
      n = len - 1 - mag;
      if (n <= 0) continue;
      d = 0;
      for (i = 0; i < n; i++) begin
        pi = s > 0 ? i + s : i;
        ci = s > 0 ? i : i - s;
        for (bb = 0; bb < 512; bb++) begin
          p = hist[pa][pi][bb];
          c = hist[pa+1][ci][bb];
          d += p > c ? p - c : c - p;
        end
      end
      if (d * best_n <= best_d * n) begin
        best_d = d;
        best_n = n;
        best = s;
      end
    end
    return best;
  endfunction

  function automatic void clear_hist();
    foreach (hist[k, i, j]) hist[k][i][j] = 0;
    pos_col = 0;
    pos_row = 0;
  endfunction

  task automatic predict_pixel(pixel_t px);
    int w, h, bin, sx, sy;
    shift_pair_t e;
    w = clamp_dim(regs_m[chsm_pkg::REG_FRAME_WIDTH]);
    h = clamp_dim(regs_m[chsm_pkg::REG_FRAME_HEIGHT]);
    bin = px.b[7:5] * 64 + px.g[7:5] * 8 + px.r[7:5];
    if (pos_col >= w) pos_col = 0;
    if (pos_row >= h) pos_row = 0;
    if (hist[px.fs ? 1 : 0][pos_col][bin] < 65535) hist[px.fs ? 1 : 0][pos_col][bin]++;
    if (hist[px.fs ? 3 : 2][pos_row][bin] < 65535) hist[px.fs ? 3 : 2][pos_row][bin]++;
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
    if (px.fin) begin
      sx = search_axis(0, w, h, $signed(regs_m[chsm_pkg::REG_DX_MIN]),
                       $signed(regs_m[chsm_pkg::REG_DX_MAX]));
      sy = search_axis(2, h, w, $signed(regs_m[chsm_pkg::REG_DY_MIN]),
                       $signed(regs_m[chsm_pkg::REG_DY_MAX]));
      e.x = sx[chsm_pkg::OUT_W-1:0];
      e.y = sy[chsm_pkg::OUT_W-1:0];
      shift_q.push_back(e);
      clear_hist();
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    pixel_t px;
    if (rst) begin
      in_valid <= 0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        px.fs = frame_sel; px.b = blue; px.g = green; px.r = red; px.fin = final_pixel;
        predict_pixel(px);
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (pixel_q.size() > 0) begin
          px = pixel_q.pop_front();
          frame_sel <= px.fs;
          blue <= px.b;
          green <= px.g;
          red <= px.r;
          final_pixel <= px.fin;
          in_valid <= 1;
          in_gap = no_idle ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    shift_pair_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results++;
        if (shift_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction x=%0d y=%0d", shift_x, shift_y);
        end else begin
          e = shift_q.pop_front();
          if (e.x !== shift_x || e.y !== shift_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: exp x=%0d y=%0d, got x=%0d y=%0d",
                       results, e.x, e.y, shift_x, shift_y);
          end
        end
        out_hold = no_idle ? 0 : $urandom_range(0, 9);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= out_hold > 0;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("color_histogram_shift_matcher regression: fail");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || shift_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    regs_m[idx] = idx < 2 ? {1'b0, val[6:0]} : val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_config(logic [7:0] w, logic [7:0] h, logic [7:0] dxl, logic [7:0] dxh,
                            logic [7:0] dyl, logic [7:0] dyh);
    wait_idle();
    cfg_write(chsm_pkg::REG_FRAME_WIDTH, w);
    cfg_write(chsm_pkg::REG_FRAME_HEIGHT, h);
    cfg_write(chsm_pkg::REG_DX_MIN, dxl);
    cfg_write(chsm_pkg::REG_DX_MAX, dxh);
    cfg_write(chsm_pkg::REG_DY_MIN, dyl);
    cfg_write(chsm_pkg::REG_DY_MAX, dyh);
  endtask

  function automatic logic [7:0] pick_color(int mode);
    case (mode)
      0: return 8'h00;
      1: return 8'hFF;
      default: return $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 1) * 8'hE0);
    endcase
  endfunction

  // one previous frame then one current frame, last pixel starts the search
  task automatic push_frame_pair(int mode);
    int w, h, k;
    pixel_t px;
    w = clamp_dim(regs_m[chsm_pkg::REG_FRAME_WIDTH]);
    h = clamp_dim(regs_m[chsm_pkg::REG_FRAME_HEIGHT]);
    for (k = 0; k < 2 * w * h; k++) begin
      px.fs = k >= w * h;
      px.b = pick_color(mode);
      px.g = pick_color(mode);
      px.r = pick_color(mode);
      px.fin = k == 2 * w * h - 1;
      pixel_q.push_back(px);
    end
  endtask

  task automatic push_noise(int count);
    pixel_t px;
    repeat (count) begin
      px.fs = $urandom_range(0, 1);
      px.b = $urandom_range(0, 255);
      px.g = $urandom_range(0, 255);
      px.r = $urandom_range(0, 255);
      px.fin = $urandom_range(0, 7) == 0;
      pixel_q.push_back(px);
    end
    px.fin = 1;
    pixel_q.push_back(px);
  endtask

  function automatic logic [7:0] rand_shift();
    return 8'($signed($urandom_range(0, 12)) - 6);
  endfunction

  initial begin
    logic [7:0] a, b;
    regs_m[0] = chsm_pkg::DIM_RESET; regs_m[1] = chsm_pkg::DIM_RESET;
    regs_m[2] = chsm_pkg::SHIFT_MIN_RESET; regs_m[3] = chsm_pkg::SHIFT_MAX_RESET;
    regs_m[4] = chsm_pkg::SHIFT_MIN_RESET; regs_m[5] = chsm_pkg::SHIFT_MAX_RESET;
    clear_hist();
    repeat (10) @(posedge clk);
    rst <= 0;

    // directed: clamped tiny frame, full shift range, black and white pixels
    set_config(8'd0, 8'd1, 8'hC0, 8'h40, 8'hC0, 8'h40);
    push_frame_pair(0);
    set_config(8'd1, 8'd130, 8'h40, 8'h40, 8'h00, 8'h00);
    push_frame_pair(1);
    // empty shift ranges give zero
    set_config(8'd3, 8'd3, 8'h05, 8'hFE, 8'h40, 8'hC0);
    push_frame_pair(2);
    // wide frame clamped to the max, two rows
    set_config(8'd127, 8'd2, 8'hFE, 8'h02, 8'hC0, 8'h40);
    push_frame_pair(2);
    // sender waits for the result before going on
    wait_idle();
    push_noise(6);

    while (sent + pixel_q.size() < 700) begin
      set_config($urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 1) | 8'h80)
                                           : 8'($urandom_range(2, 6)),
                 $urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 1) | 8'h80)
                                           : 8'($urandom_range(2, 6)),
                 8'h00, 8'h00, 8'h00, 8'h00);
      a = rand_shift(); b = rand_shift();
      if ($urandom_range(0, 2) == 0) begin a = 8'hC0; b = 8'h40; end
      cfg_write(chsm_pkg::REG_DX_MIN, a);
      cfg_write(chsm_pkg::REG_DX_MAX, b);
      a = rand_shift(); b = rand_shift();
      if ($urandom_range(0, 2) == 0) begin a = 8'hC0; b = 8'h40; end
      cfg_write(chsm_pkg::REG_DY_MIN, a);
      cfg_write(chsm_pkg::REG_DY_MAX, b);
      no_idle = $urandom_range(0, 3) == 0;
      if ($urandom_range(0, 4) == 0) push_noise($urandom_range(4, 20));
      else push_frame_pair(2);
    end

    while (pixel_q.size() > 0 || in_valid || shift_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && shift_q.size() == 0)
      $display("color_histogram_shift_matcher regression: pass");
    else
      $display("color_histogram_shift_matcher regression: fail");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/chsm_pkg.sv
hw/rtl/color_histogram_shift_matcher.sv
bench/tb_color_histogram_shift_matcher.sv
